// ===== rtl/b64d_pkg.sv =====
package b64d_pkg;

  localparam logic [7:0] CODE_BAD  = 8'd255;
  localparam logic [7:0] CODE_PAD  = 8'd254;
  localparam logic [7:0] CODE_SKIP = 8'd253;

  typedef enum logic [1:0] {
    ST_DATA = 2'd0,
    ST_DONE = 2'd1,
    ST_BAD  = 2'd2
  } b64d_status_t;

  typedef struct packed {
    logic [7:0]   data;
    b64d_status_t status;
  } b64d_result_t;

  // Up to three data bytes and one done status come out of a single character.
  typedef struct packed {
    logic [2:0]          count;
    b64d_result_t [3:0]  slot;
  } b64d_bundle_t;

  // Maps a text byte to its sextet value or to one of the special codes.
  function automatic logic [7:0] b64d_classify(input logic [7:0] ch);
    logic [7:0] code;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      code = ch - 8'd65;
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      code = ch - 8'd71;
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      code = ch + 8'd4;
    end else if (ch == 8'h2B) begin
      code = 8'd62;
    end else if (ch == 8'h2F) begin
      code = 8'd63;
    end else if (ch == 8'h0A || ch == 8'h0D || ch == 8'h20) begin
      code = CODE_SKIP;
    end else if (ch == 8'h3D) begin
      code = CODE_PAD;
    end else begin
      code = CODE_BAD;
    end
    return code;
  endfunction

endpackage

// ===== rtl/b64d_if.sv =====
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last_char;

  modport source (output valid, output character, output last_char, input ready);
  modport sink (input valid, input character, input last_char, output ready);
endinterface

interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       run_end;

  modport source (output valid, output out_byte, output status, output run_end,
                  input ready);
  modport sink (input valid, input out_byte, input status, input run_end,
                output ready);
endinterface

// ===== rtl/b64d_decode.sv =====
module b64d_decode (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire_i,
  input  logic [7:0]            char_i,
  input  logic                  last_i,
  output b64d_pkg::b64d_bundle_t bundle_o
);
  import b64d_pkg::*;

  logic [17:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic        err_r, err_nxt;

  logic [7:0]  code;
  logic [5:0]  sextet;
  logic [23:0] group;
  logic [1:0]  pad_inc;
  logic [1:0]  nd;
  logic        bad;
  logic [2:0]  n;

  always_comb begin
    code    = b64d_classify(char_i);
    sextet  = (code == CODE_PAD) ? 6'd0 : code[5:0];
    group   = {acc_r, sextet};
    pad_inc = (pad_r == 2'd2) ? 2'd2 : pad_r + 2'd1;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    pad_nxt = pad_r;
    err_nxt = err_r;
    nd      = 2'd0;
    bad     = 1'b0;
    if (!err_r) begin
      if (code == CODE_BAD) begin
        bad     = 1'b1;
        err_nxt = 1'b1;
      end else if (code != CODE_SKIP) begin
        if (code == CODE_PAD) begin
          pad_nxt = pad_inc;
        end
        acc_nxt = group[17:0];
        if (cnt_r == 2'd3) begin
          // The pad count covers the whole message, so it trims every later group.
          nd      = (pad_nxt == 2'd0) ? 2'd3 : ((pad_nxt == 2'd1) ? 2'd2 : 2'd1);
          acc_nxt = '0;
          cnt_nxt = 2'd0;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end
    end
    if (last_i) begin
      acc_nxt = '0;
      cnt_nxt = 2'd0;
      pad_nxt = 2'd0;
      err_nxt = 1'b0;
    end
  end

  always_comb begin
    bundle_o.slot[0] = '{data: group[23:16], status: ST_DATA};
    bundle_o.slot[1] = '{data: group[15:8], status: ST_DATA};
    bundle_o.slot[2] = '{data: group[7:0], status: ST_DATA};
    bundle_o.slot[3] = '{data: 8'd0, status: ST_DONE};
    if (bad) begin
      bundle_o.slot[0] = '{data: 8'd0, status: ST_BAD};
      n = 3'd1;
    end else begin
      n = {1'b0, nd};
    end
    if (last_i) begin
      bundle_o.slot[n[1:0]] = '{data: 8'd0, status: ST_DONE};
      n = n + 3'd1;
    end
    bundle_o.count = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= 2'd0;
      pad_r <= 2'd0;
      err_r <= 1'b0;
    end else if (fire_i) begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      pad_r <= pad_nxt;
      err_r <= err_nxt;
    end
  end

endmodule

// ===== rtl/base64_decoder_stream.sv =====
// Streaming base64 decoder.
// The in_ch channel takes one text character per request, with last_char set
// on the final character of a message. The out_ch channel gives one result per
// request: a decoded byte, a done status after the final character, or a single
// bad-character status after which the rest of the message is dropped.
// Line feed, carriage return and space are skipped and give no result.
// A character is held in an input register, decoded against the running group
// and pad count, and its results are loaded into a result buffer that hands
// them out one per cycle while the receiver is ready, with run_end on the last one.
// A character passes the input register and the result buffer before its first result.
// While the receiver is ready, a character that causes at most one result is
// taken every cycle; one that completes a group (up to four results if it also
// ends the message) holds the next character back until its last result is taken.
// When the receiver stalls, the buffer holds its results and the next
// character waits in the input register; in_ch.ready falls once both are full.
// Reset clears the partial group, the pad count, the error flag and all
// pending results.
module base64_decoder_stream (
  input  logic       clk,
  input  logic       rst_n,
  b64d_in_if.sink    in_ch,
  b64d_out_if.source out_ch
);
  import b64d_pkg::*;

  logic         in_valid_r;
  logic [7:0]   in_char_r;
  logic         in_last_r;

  logic         bnd_valid_r, bnd_valid_nxt;
  logic [2:0]   bnd_cnt_r, bnd_cnt_nxt;
  b64d_result_t [3:0] bnd_slot_r, bnd_slot_nxt;

  b64d_bundle_t dec_bundle;
  logic         out_fire;
  logic         last_out;
  logic         move;

  assign out_fire = out_ch.valid && out_ch.ready;
  assign last_out = out_fire && (bnd_cnt_r == 3'd1);
  assign move     = in_valid_r && (!bnd_valid_r || last_out);

  assign in_ch.ready     = !in_valid_r || move;
  assign out_ch.valid    = bnd_valid_r;
  assign out_ch.out_byte = bnd_slot_r[0].data;
  assign out_ch.status   = bnd_slot_r[0].status;
  assign out_ch.run_end  = (bnd_cnt_r == 3'd1);

  b64d_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire_i   (move),
    .char_i   (in_char_r),
    .last_i   (in_last_r),
    .bundle_o (dec_bundle)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_char_r <= in_ch.character;
      in_last_r <= in_ch.last_char;
    end
  end

  always_comb begin
    bnd_valid_nxt = bnd_valid_r;
    bnd_cnt_nxt   = bnd_cnt_r;
    bnd_slot_nxt  = bnd_slot_r;
    if (move) begin
      bnd_valid_nxt = (dec_bundle.count != 3'd0);
      bnd_cnt_nxt   = dec_bundle.count;
      bnd_slot_nxt  = dec_bundle.slot;
    end else if (out_fire) begin
      bnd_valid_nxt = !last_out;
      bnd_cnt_nxt   = bnd_cnt_r - 3'd1;
      bnd_slot_nxt  = {bnd_slot_r[3], bnd_slot_r[3:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bnd_valid_r <= 1'b0;
      bnd_cnt_r   <= 3'd0;
    end else begin
      bnd_valid_r <= bnd_valid_nxt;
      bnd_cnt_r   <= bnd_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bnd_slot_r <= bnd_slot_nxt;
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    bnd_valid_r |-> (bnd_cnt_r != 3'd0) && (bnd_cnt_r <= 3'd4))
    else $error("result buffer holds an impossible count");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && (bnd_cnt_r > 3'd1)) |=> out_ch.valid)
    else $error("results of one character were split by a gap");

  a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status == ST_DONE)) |-> out_ch.run_end)
    else $error("done status is not the last result of its character");

  a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !move) |=> in_valid_r && $stable(in_char_r) && $stable(in_last_r))
    else $error("waiting character was lost or changed");
`endif

endmodule
